>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/mcmc_pkg.sv
// Shared types and constants for the matrix-chain cost block.
package mcmc_pkg;

   localparam int DIM_IN_W   = 12;
   localparam int COST_OUT_W = 40;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

   localparam logic [COST_OUT_W-1:0] COST_MAX = {COST_OUT_W{1'b1}};

   // control travelling with one split step through the cost pipeline
   typedef struct packed {
      logic valid;
      logic last;        // final split of the cell
      logic left_zero;   // left term is a diagonal entry (also first split)
      logic right_zero;  // right term is a diagonal entry
   } step_ctrl_type;

endpackage

>>> rtl/mcmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mcmc_step.sv
// Split-evaluation pipeline: product, sum and running minimum for one cell.
module mcmc_step #(
   parameter int DIM_BITS = 12,
   parameter int COST_W   = 41
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mcmc_pkg::step_ctrl_type      issue,      // split issued this cycle
   input  logic [DIM_BITS-1:0]          dim_i,
   input  logic [DIM_BITS-1:0]          dim_k1,     // read data, aligned with stage 1
   input  logic [DIM_BITS-1:0]          dim_j1,
   input  logic [COST_W-1:0]            cost_left,  // read data, aligned with stage 1
   input  logic [COST_W-1:0]            cost_right,
   output logic                         wr_valid,
   output logic [COST_W-1:0]            wr_cost
);

   localparam int PA_W = 2 * DIM_BITS;
   localparam int PB_W = 3 * DIM_BITS;

   mcmc_pkg::step_ctrl_type s1_ff, s2_ff, s3_ff;
   logic [PA_W-1:0]   s2_prod_ff;
   logic [COST_W-1:0] s2_sum_ff, s3_sum_ff;
   logic [PB_W-1:0]   s3_prod_ff;
   logic [COST_W-1:0] best_ff, best_in;
   logic [COST_W-1:0] sum_in, cand;
   logic [PA_W-1:0]   prod_a_in;
   logic [PB_W-1:0]   prod_b_in;

   always_comb begin
      sum_in    = (s1_ff.left_zero  ? '0 : cost_left)
                + (s1_ff.right_zero ? '0 : cost_right);
      prod_a_in = PA_W'(dim_i) * PA_W'(dim_k1);
      prod_b_in = PB_W'(s2_prod_ff) * PB_W'(dim_j1);
      cand      = s3_sum_ff + COST_W'(s3_prod_ff);
      best_in   = best_ff;
      if (s3_ff.valid && (s3_ff.left_zero || cand < best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
      s2_prod_ff <= prod_a_in;
      s2_sum_ff  <= sum_in;
      s3_prod_ff <= prod_b_in;
      s3_sum_ff  <= s2_sum_ff;
      best_ff    <= best_in;
   end

   assign wr_valid = s3_ff.valid && s3_ff.last;
   assign wr_cost  = best_in;

endmodule

>>> rtl/matrix_chain_min_cost.sv
// Top level: dimension loader, table sequencer and result register.
//
// Usage
//  - req channel: one dimension per beat (tdata[11:0]), tlast on the final
//    dimension of a sequence p0..pn. Beats are taken one per cycle while
//    loading; after the tlast beat req_tready drops until the result is
//    parked in the output register.
//  - rsp channel: one beat per tlast beat; tdata = {pad, status, min_cost}.
//    status 1 = fewer than two dimensions, 2 = sequence too long for the
//    table; min_cost is 0 then.
//  - After the tlast beat, a single matrix or an error goes straight to
//    S_OUT; otherwise each table cell (i,j) of chain length L runs two dims
//    reads, L-1 split steps and a 3-deep drain, and the minimum of the final
//    cell is parked as the result.
//  - Throughput is set by the one split step per cycle through the cost
//    table memories (two read-port copies) and the drain between cells.
//  - Reset: synchronous, clears the sequencer, the load count, the overflow
//    flag and rsp_tvalid. No memory clearing pass is needed.
//  - A stalled rsp holds its beat; loading of the next sequence goes on
//    meanwhile, and only its own result waits for the register to free up.
module matrix_chain_min_cost #(
   parameter int MAX_MATRICES = 16,
   parameter int DIM_BITS     = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] dimension, [15:12] zero
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [39:0] min_cost, [41:40] status, [47:42] zero
);

   localparam int STORE_DEPTH = MAX_MATRICES + 1;
   localparam int TAB_DEPTH   = MAX_MATRICES * MAX_MATRICES;
   localparam int IW          = $clog2(MAX_MATRICES + 1);     // indexes 0..MAX
   localparam int LW          = $clog2(STORE_DEPTH + 1);      // load count 0..DEPTH
   localparam int TAW         = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
   localparam int COST_W      = 3 * DIM_BITS + $clog2(MAX_MATRICES + 1);

   typedef enum logic [2:0] {
      S_LOAD,    // taking dimension beats
      S_SETUP0,  // read p(i)
      S_SETUP1,  // read p(j+1), capture p(i)
      S_LOOP,    // one split k per cycle
      S_DRAIN,   // wait for the cell's minimum to be written
      S_OUT      // park result in the output register
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, len_ff, len_in, k_ff, k_in, n_ff, n_in;
   logic [LW-1:0] loaded_ff, loaded_in;
   logic          ovf_ff, ovf_in;
   logic [DIM_BITS-1:0] pi_ff, pi_in, pj1_ff, pj1_in;
   logic [mcmc_pkg::COST_OUT_W-1:0] res_cost_ff, res_cost_in;
   logic [mcmc_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [mcmc_pkg::COST_OUT_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [mcmc_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                req_beat;
   logic [DIM_BITS+mcmc_pkg::DIM_IN_W-1:0] dim_ext;
   logic [DIM_BITS-1:0] dim_val;
   logic [IW-1:0]       j_cur;
   logic [LW-1:0]       loaded_next;
   logic                ovf_next;

   logic                dims_wr_en;
   logic [IW-1:0]       dims_rd_addr;
   logic [DIM_BITS-1:0] dims_rd_data;
   logic [TAW-1:0]      tab_addr_l, tab_addr_r, tab_wr_addr;
   logic [COST_W-1:0]   cost_l, cost_r, wr_cost;
   logic                wr_valid;
   logic [63:0]         cost_wide;
   logic [mcmc_pkg::COST_OUT_W-1:0] cost_sat;
   mcmc_pkg::step_ctrl_type issue;

   // input beat, dimension masked to DIM_BITS
   assign req_tready = (state_ff == S_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign dim_ext    = {{DIM_BITS{1'b0}}, req_tdata[mcmc_pkg::DIM_IN_W-1:0]};
   assign dim_val    = dim_ext[DIM_BITS-1:0];

   assign dims_wr_en  = req_beat && (loaded_ff < LW'(STORE_DEPTH));
   assign loaded_next = dims_wr_en ? loaded_ff + LW'(1) : loaded_ff;
   assign ovf_next    = ovf_ff || !dims_wr_en;

   assign j_cur = i_ff + len_ff - IW'(1);

   // split step issue; addresses for left/right cost terms and p(k+1)
   always_comb begin
      issue.valid      = (state_ff == S_LOOP);
      issue.last       = (k_ff == j_cur - IW'(1));
      issue.left_zero  = (k_ff == i_ff);
      issue.right_zero = (k_ff + IW'(1) == j_cur);
      tab_addr_l  = TAW'(i_ff) * TAW'(MAX_MATRICES) + TAW'(k_ff);
      tab_addr_r  = TAW'(k_ff + IW'(1)) * TAW'(MAX_MATRICES) + TAW'(j_cur);
      tab_wr_addr = TAW'(i_ff) * TAW'(MAX_MATRICES) + TAW'(j_cur);
      case (state_ff)
         S_SETUP0: dims_rd_addr = i_ff;
         S_SETUP1: dims_rd_addr = j_cur + IW'(1);
         S_LOOP:   dims_rd_addr = k_ff + IW'(1);
         default:  dims_rd_addr = i_ff;
      endcase
   end

   // saturate to the 40-bit result field
   assign cost_wide = 64'(wr_cost);
   assign cost_sat  = (cost_wide > 64'(mcmc_pkg::COST_MAX))
                    ? mcmc_pkg::COST_MAX : cost_wide[mcmc_pkg::COST_OUT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      loaded_in     = loaded_ff;
      ovf_in        = ovf_ff;
      pi_in         = pi_ff;
      pj1_in        = pj1_ff;
      res_cost_in   = res_cost_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cost_in   = rsp_cost_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_beat) begin
               loaded_in = loaded_next;
               ovf_in    = ovf_next;
               if (req_tlast) begin
                  loaded_in     = '0;
                  ovf_in        = 1'b0;
                  res_cost_in   = '0;
                  res_status_in = mcmc_pkg::STATUS_OK;
                  n_in          = IW'(loaded_next - LW'(1));
                  i_in          = '0;
                  len_in        = IW'(2);
                  state_in      = S_OUT;
                  if (ovf_next) begin
                     res_status_in = mcmc_pkg::STATUS_LONG;
                  end else if (loaded_next < LW'(2)) begin
                     res_status_in = mcmc_pkg::STATUS_SHORT;
                  end else if (loaded_next > LW'(2)) begin
                     state_in = S_SETUP0;
                  end
               end
            end
         end
         S_SETUP0: begin
            k_in     = i_ff;
            state_in = S_SETUP1;
         end
         S_SETUP1: begin
            pi_in    = dims_rd_data;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (issue.left_zero) begin
               pj1_in = dims_rd_data;
            end
            if (issue.last) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            if (wr_valid) begin
               state_in = S_SETUP0;
               if (len_ff == n_ff) begin
                  res_cost_in = cost_sat;
                  state_in    = S_OUT;
               end else if (j_cur == n_ff - IW'(1)) begin
                  len_in = len_ff + IW'(1);
                  i_in   = '0;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_cost_in   = res_cost_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         len_ff       <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         len_ff       <= len_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
      end
      pi_ff         <= pi_in;
      pj1_ff        <= pj1_in;
      res_cost_ff   <= res_cost_in;
      res_status_ff <= res_status_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_status_ff <= rsp_status_in;
   end

   // dimension store
   mcmc_ram #(
      .WIDTH (DIM_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_dims (
      .clock   (clock),
      .wr_en   (dims_wr_en),
      .wr_addr (loaded_ff[IW-1:0]),
      .wr_data (dim_val),
      .rd_addr (dims_rd_addr),
      .rd_data (dims_rd_data)
   );

   // cost table, two copies so both terms of a split read in the same cycle
   mcmc_ram #(
      .WIDTH (COST_W),
      .DEPTH (TAB_DEPTH)
   ) u_cost_l (
      .clock   (clock),
      .wr_en   (wr_valid),
      .wr_addr (tab_wr_addr),
      .wr_data (wr_cost),
      .rd_addr (tab_addr_l),
      .rd_data (cost_l)
   );

   mcmc_ram #(
      .WIDTH (COST_W),
      .DEPTH (TAB_DEPTH)
   ) u_cost_r (
      .clock   (clock),
      .wr_en   (wr_valid),
      .wr_addr (tab_wr_addr),
      .wr_data (wr_cost),
      .rd_addr (tab_addr_r),
      .rd_data (cost_r)
   );

   mcmc_step #(
      .DIM_BITS (DIM_BITS),
      .COST_W   (COST_W)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .dim_i      (pi_ff),
      .dim_k1     (dims_rd_data),
      .dim_j1     (pj1_ff),
      .cost_left  (cost_l),
      .cost_right (cost_r),
      .wr_valid   (wr_valid),
      .wr_cost    (wr_cost)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_cost_ff};

endmodule

>>> rtl/mcmc_checker.sv
// Port-level checker for the matrix-chain cost block, bound to the top level.
`include "assert_macros.svh"

module mcmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic        req_beat_end;
   logic [1:0]  rsp_status;
   logic [39:0] rsp_cost;

   assign req_beat_end = req_tvalid && req_tready && req_tlast;
   assign rsp_status   = rsp_tdata[41:40];
   assign rsp_cost     = rsp_tdata[39:0];

   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NOW(a_err_zero_cost, rsp_tvalid && rsp_status != mcmc_pkg::STATUS_OK, rsp_cost == 40'd0)
   `ASSERT_NOW(a_status_code, rsp_tvalid, rsp_status <= mcmc_pkg::STATUS_LONG)
   `ASSERT_NEXT(a_busy_after_end, req_beat_end, !req_tready)
   `ASSERT_ALWAYS_NEXT(a_reset_clear, reset, !rsp_tvalid && req_tready)

endmodule

bind matrix_chain_min_cost mcmc_checker u_mcmc_checker (.*);
